// ===== sv/swhsr_pkg.sv =====
// Package for the single-wire humidity sensor reader.
// Holds the phase type, the status and register index codes, and the reset values.
// It depends on nothing else.
package swhsr_pkg;

	localparam int DATA_BITS_DEF   = 40;
	localparam int TIMER_WIDTH_DEF = 16;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd3;

	localparam logic [15:0] START_LOW_RST = 16'd18000;
	localparam logic [7:0]  RELEASE_RST   = 8'd30;
	localparam logic [7:0]  TIMEOUT_RST   = 8'd100;
	localparam logic [7:0]  THRESHOLD_RST = 8'd50;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_CSUM    = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_LOW = 4'd1,
		PH_RELEASE   = 4'd2,
		PH_WAIT_RESP = 4'd3,
		PH_RESP_LOW  = 4'd4,
		PH_RESP_HIGH = 4'd5,
		PH_BIT_LOW   = 4'd6,
		PH_BIT_HIGH  = 4'd7
	} phase_t;

endpackage

// ===== sv/swhsr_if.sv =====
// Valid/ready channel interfaces of the single-wire humidity sensor reader.
// swhsr_tick_if carries one sample tick, swhsr_result_if one result item.
// They depend on nothing else.
interface swhsr_tick_if;
	logic valid;
	logic ready;
	logic start_request;
	logic line_level;

	modport source (output valid, output start_request, output line_level, input ready);
	modport sink   (input valid, input start_request, input line_level, output ready);
endinterface

interface swhsr_result_if;
	logic       valid;
	logic       ready;
	logic       line_drive_low;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] humidity_whole;
	logic [7:0] humidity_tenths;
	logic [7:0] temperature_whole;
	logic [7:0] temperature_tenths;
	logic [7:0] checksum_byte;

	modport source (
		output valid, output line_drive_low, output busy_res, output done_res,
		output status, output humidity_whole, output humidity_tenths,
		output temperature_whole, output temperature_tenths, output checksum_byte,
		input ready
	);
	modport sink (
		input valid, input line_drive_low, input busy_res, input done_res,
		input status, input humidity_whole, input humidity_tenths,
		input temperature_whole, input temperature_tenths, input checksum_byte,
		output ready
	);
endinterface

// ===== sv/single_wire_humidity_sensor_reader.sv =====
// Top level of the single-wire humidity sensor reader.
// Uses swhsr_pkg and the channel interfaces in swhsr_if.sv.
//
//  channel | dir | items                    | fields
//  --------+-----+--------------------------+----------------------------------------
//  tick    | in  | one per microsecond tick | start_request, line_level
//  result  | out | one per accepted tick    | line_drive_low, busy_res, done_res,
//          |     |                          | status, five received bytes
//  cfg     | in  | register writes          | cfg_we, cfg_index, cfg_data
//
// Each tick item updates the sequencer in the cycle it is accepted; its result lands
// in the result register on the same edge, so one item is taken every cycle unless the
// result is stalled. A single result register holds the output.
// Reset clears the sequencer, the held bytes and status, and loads the register defaults.
// A stalled result holds the register; a new tick is taken in the same cycle the
// waiting result leaves, and only then.
module single_wire_humidity_sensor_reader
	import swhsr_pkg::*;
#(
	parameter int DATA_BITS   = DATA_BITS_DEF,
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	swhsr_tick_if.sink             tick,
	swhsr_result_if.source         result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW  = 32;
	localparam int BCW = $clog2(DATA_BITS + 1);
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	// configuration registers
	logic [15:0] start_low_q;
	logic [7:0]  release_q;
	logic [7:0]  timeout_q;
	logic [7:0]  threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q <= START_LOW_RST;
			release_q   <= RELEASE_RST;
			timeout_q   <= TIMEOUT_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_LOW: start_low_q <= cfg_data;
				CFG_RELEASE:   release_q   <= cfg_data[7:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data[7:0];
				CFG_THRESHOLD: threshold_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic [BCW-1:0]         bits_q, bits_d;
	logic [DATA_BITS-1:0]   shift_q, shift_d;
	logic [DATA_BITS-1:0]   held_q, held_d;
	logic [1:0]             status_q, status_d;
	logic                   done_d;

	// handshake: take a tick when the result register is empty or draining
	logic res_valid_q;
	logic tick_fire;
	assign tick.ready = !res_valid_q || result.ready;
	assign tick_fire  = tick.valid && tick.ready;

	logic [TIMER_WIDTH-1:0] timer_inc;
	logic [CW-1:0]          timer_inc_x;
	logic [BCW-1:0]         bits_inc;
	logic                   stay_level;
	logic                   bit_val;
	logic [DATA_BITS-1:0]   shift_push;
	logic [7:0]             sd_byte [5];
	logic [7:0]             hb_byte [5];
	logic [7:0]             csum;

	assign timer_inc   = (timer_q == TIMER_MAX) ? TIMER_MAX : timer_q + 1'b1;
	assign timer_inc_x = CW'(timer_inc);
	assign bits_inc    = bits_q + 1'b1;
	assign stay_level  = !(phase_q == PH_RESP_LOW || phase_q == PH_BIT_LOW);
	assign bit_val     = CW'(timer_q) > CW'(threshold_q);
	assign shift_push  = {shift_q[DATA_BITS-2:0], bit_val};

	// bytes from the top of the received bits; a byte not fully covered by the bits reads as zero
	for (genvar k = 0; k < 5; k++) begin : g_byte
		localparam int SH = DATA_BITS - 8 * (k + 1);
		if (SH >= 0) begin : g_have
			assign sd_byte[k] = shift_push[SH +: 8];
			assign hb_byte[k] = held_d[SH +: 8];
		end else begin : g_none
			assign sd_byte[k] = 8'd0;
			assign hb_byte[k] = 8'd0;
		end
	end

	assign csum = sd_byte[0] + sd_byte[1] + sd_byte[2] + sd_byte[3];

	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		bits_d   = bits_q;
		shift_d  = shift_q;
		held_d   = held_q;
		status_d = status_q;
		done_d   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (tick.start_request) begin
					phase_d = PH_START_LOW;
					timer_d = '0;
					bits_d  = '0;
					shift_d = '0;
				end
			end
			PH_START_LOW: begin
				timer_d = timer_inc;
				if (timer_inc_x >= CW'(start_low_q) || timer_inc == TIMER_MAX) begin
					phase_d = (release_q == 8'd0) ? PH_WAIT_RESP : PH_RELEASE;
					timer_d = '0;
				end
			end
			PH_RELEASE: begin
				timer_d = timer_inc;
				if (timer_inc_x >= CW'(release_q) || timer_inc == TIMER_MAX) begin
					phase_d = PH_WAIT_RESP;
					timer_d = '0;
				end
			end
			PH_WAIT_RESP, PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
				if (tick.line_level == stay_level) begin
					// still in the phase: count, and fail past the timeout
					timer_d = timer_inc;
					if (timer_inc_x > CW'(timeout_q)) begin
						status_d = ST_TIMEOUT;
						phase_d  = PH_IDLE;
						timer_d  = '0;
						bits_d   = '0;
						done_d   = 1'b1;
					end
				end else if (phase_q == PH_BIT_HIGH) begin
					// falling edge ends a bit: decode by the high pulse length
					shift_d = shift_push;
					bits_d  = bits_inc;
					if (bits_inc >= BCW'(DATA_BITS)) begin
						held_d   = shift_push;
						status_d = (csum == sd_byte[4]) ? ST_OK : ST_CSUM;
						phase_d  = PH_IDLE;
						timer_d  = '0;
						bits_d   = '0;
						done_d   = 1'b1;
					end else begin
						phase_d = PH_BIT_LOW;
						timer_d = TIMER_WIDTH'(1);
					end
				end else begin
					// edge ends the phase; this sample opens the next one
					case (phase_q)
						PH_WAIT_RESP: phase_d = PH_RESP_LOW;
						PH_RESP_LOW:  phase_d = PH_RESP_HIGH;
						PH_RESP_HIGH: phase_d = PH_BIT_LOW;
						default:      phase_d = PH_BIT_HIGH;
					endcase
					timer_d = TIMER_WIDTH'(1);
				end
			end
			default: begin
				phase_d = PH_IDLE;
				timer_d = '0;
				bits_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			bits_q   <= '0;
			shift_q  <= '0;
			held_q   <= '0;
			status_q <= ST_OK;
		end else if (tick_fire) begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			bits_q   <= bits_d;
			shift_q  <= shift_d;
			held_q   <= held_d;
			status_q <= status_d;
		end
	end

	// result register
	logic       drive_q, busy_q, done_q;
	logic [1:0] res_status_q;
	logic [7:0] res_byte_q [5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick.ready) begin
			res_valid_q <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			drive_q      <= (phase_d == PH_START_LOW);
			busy_q       <= (phase_d != PH_IDLE);
			done_q       <= done_d;
			res_status_q <= status_d;
			for (int k = 0; k < 5; k++) begin
				res_byte_q[k] <= hb_byte[k];
			end
		end
	end

	assign result.valid              = res_valid_q;
	assign result.line_drive_low     = drive_q;
	assign result.busy_res           = busy_q;
	assign result.done_res           = done_q;
	assign result.status             = res_status_q;
	assign result.humidity_whole     = res_byte_q[0];
	assign result.humidity_tenths    = res_byte_q[1];
	assign result.temperature_whole  = res_byte_q[2];
	assign result.temperature_tenths = res_byte_q[3];
	assign result.checksum_byte      = res_byte_q[4];

endmodule
